[rtl/sldf_pkg.sv]
// shared types and constants for the sensor log record deframer
package sldf_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned POS_W  = 8;

    localparam logic [7:0] ESCAPE_CODE = 8'd255;
    localparam logic [7:0] ID_SENSOR   = 8'd20;
    localparam logic [7:0] ID_GNSS     = 8'd30;
    localparam logic [7:0] ID_DGNSS    = 8'd31;
    localparam logic [7:0] MAIN_WORDS  = 8'd13;
    localparam logic [7:0] TAIL_WORDS  = 8'd4;
    localparam logic [7:0] FIX_WORD    = 8'd10;
    localparam logic [WORD_W-1:0] EXT_MIN_LEN = 32'd3;
    localparam logic [POS_W-1:0] POS_MAX = 8'd255;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXT_ID  = 2'd1,
        PH_EXT_LEN = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CL_UNKNOWN = 2'd0,
        CL_SENSOR  = 2'd1,
        CL_GNSS    = 2'd2,
        CL_DGNSS   = 2'd3
    } rec_class_t;

    typedef enum logic [3:0] {
        KIND_HEADER  = 4'd0,
        KIND_EXT_ID  = 4'd1,
        KIND_EXT_LEN = 4'd2,
        KIND_SENSOR  = 4'd3,
        KIND_GNSS    = 4'd4,
        KIND_TAIL    = 4'd5,
        KIND_SKIP    = 4'd6,
        KIND_ERROR   = 4'd7,
        KIND_IGNORED = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t            word_kind;
        logic [POS_W-1:0] payload_index;
        logic             last_of_record;
        logic             has_fix;
        logic             stopped;
    } result_t;

endpackage

[rtl/sldf_core.sv]
// record parser state and per-word tagging logic
module sldf_core
    import sldf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [WORD_W-1:0] in_word,
    output result_t           res
);

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] words_left_reg, words_left_next;
    rec_class_t        class_reg, class_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              fix_seen_reg, fix_seen_next;
    logic              halted_reg, halted_next;

    logic [7:0]        hdr_id;
    logic [7:0]        hdr_len;
    logic [7:0]        hdr_payload;
    logic [WORD_W-1:0] begin_count;
    rec_class_t        begin_class;
    logic              begin_en;
    logic              is_gnss;
    logic              fix_now;

    function automatic rec_class_t classify(input logic [7:0] id, input logic [7:0] payload);
        rec_class_t c;
        c = CL_UNKNOWN;
        if (id == ID_SENSOR && payload >= MAIN_WORDS)
            c = CL_SENSOR;
        else if (id == ID_GNSS && payload >= MAIN_WORDS)
            c = CL_GNSS;
        else if (id == ID_DGNSS && payload >= (MAIN_WORDS + TAIL_WORDS))
            c = CL_DGNSS;
        return c;
    endfunction

    assign hdr_id      = in_word[7:0];
    assign hdr_len     = in_word[15:8];
    assign hdr_payload = hdr_len - 8'd1;
    assign is_gnss     = (class_reg == CL_GNSS) || (class_reg == CL_DGNSS);
    assign fix_now     = (is_gnss && pos_reg == FIX_WORD) ? in_word[24] : fix_seen_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        class_next      = class_reg;
        pos_next        = pos_reg;
        fix_seen_next   = fix_seen_reg;
        halted_next     = halted_reg;
        begin_en        = 1'b0;
        begin_count     = '0;
        begin_class     = CL_UNKNOWN;
        res.word_kind      = KIND_IGNORED;
        res.payload_index  = '0;
        res.last_of_record = 1'b0;
        res.has_fix        = 1'b0;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_id == ESCAPE_CODE && hdr_len == ESCAPE_CODE)
                    begin
                        res.word_kind = KIND_HEADER;
                        phase_next    = PH_EXT_ID;
                    end
                    else if (hdr_len == 8'd0)
                    begin
                        res.word_kind = KIND_ERROR;
                        halted_next   = 1'b1;
                    end
                    else
                    begin
                        res.word_kind = KIND_HEADER;
                        begin_en      = 1'b1;
                        begin_count   = {{(WORD_W-8){1'b0}}, hdr_payload};
                        begin_class   = classify(hdr_id, hdr_payload);
                    end
                end
                PH_EXT_ID:
                begin
                    res.word_kind = KIND_EXT_ID;
                    phase_next    = PH_EXT_LEN;
                end
                PH_EXT_LEN:
                begin
                    if (in_word < EXT_MIN_LEN)
                    begin
                        res.word_kind = KIND_ERROR;
                        halted_next   = 1'b1;
                        phase_next    = PH_HEADER;
                    end
                    else
                    begin
                        res.word_kind = KIND_EXT_LEN;
                        begin_en      = 1'b1;
                        begin_count   = in_word - EXT_MIN_LEN;
                        begin_class   = CL_UNKNOWN;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.payload_index = pos_reg;
                    unique case (class_reg)
                        CL_SENSOR:
                            res.word_kind = (pos_reg < MAIN_WORDS) ? KIND_SENSOR : KIND_SKIP;
                        CL_GNSS:
                            res.word_kind = (pos_reg < MAIN_WORDS) ? KIND_GNSS : KIND_SKIP;
                        CL_DGNSS:
                            res.word_kind = (pos_reg < MAIN_WORDS) ? KIND_GNSS :
                                (pos_reg < (MAIN_WORDS + TAIL_WORDS)) ? KIND_TAIL : KIND_SKIP;
                        default:
                            res.word_kind = KIND_SKIP;
                    endcase
                    fix_seen_next = fix_now;
                    if (pos_reg != POS_MAX)
                        pos_next = pos_reg + 8'd1;
                    if (words_left_reg != '0)
                        words_left_next = words_left_reg - 32'd1;
                    if (words_left_reg <= 32'd1)
                    begin
                        res.last_of_record = 1'b1;
                        res.has_fix        = is_gnss & fix_now;
                        phase_next         = PH_HEADER;
                    end
                end
                default:
                    phase_next = PH_HEADER;
            endcase
        end

        if (begin_en)
        begin
            words_left_next = begin_count;
            class_next      = begin_class;
            pos_next        = '0;
            fix_seen_next   = 1'b0;
            if (begin_count == '0)
            begin
                res.last_of_record = 1'b1;
                phase_next         = PH_HEADER;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end

        res.stopped = halted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            words_left_reg <= '0;
            class_reg      <= CL_UNKNOWN;
            pos_reg        <= '0;
            fix_seen_reg   <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            class_reg      <= class_next;
            pos_reg        <= pos_next;
            fix_seen_reg   <= fix_seen_next;
            halted_reg     <= halted_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (words_left_reg != '0))
        else $error("payload phase with no words left");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && res.word_kind == KIND_ERROR) |=> halted_reg)
        else $error("error word did not halt the parser");
`endif

endmodule

[rtl/sldf_skid.sv]
// output register with skid stage for result transactions
module sldf_skid
    import sldf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    accept;
    logic    drain;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign drain     = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
            out_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        else if (accept)
            skid_res_reg <= in_res;
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stall_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped during stall");

    a_skid_refills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output register");
`endif

endmodule

[rtl/sensor_log_record_deframer_top.sv]
// sensor log record deframer: tags each log word of a stream
//
// input: one 32-bit little-endian log word per s_ transaction
// output: one tag per input word on the m_ channel, in order
//   m_tuser carries the word kind, m_tlast marks the end of a record,
//   m_tdata carries payload index, fix flag and stopped flag
// the tag of a word is offered from the output register, reached via the skid register during a stall
// throughput: one word per cycle while s_tready is high, set by the single parser state update
// a two-entry output buffer (output register plus skid register) lets a
//   new word in while a tag waits; s_tready drops only when both are full
// a stalled receiver holds m_tdata, m_tuser and m_tlast steady until taken
// reset clears the parser to expect a header word and empties the buffer
// a zero header length or an extended length below three stops parsing;
//   every later word is tagged ignored with stopped set until reset
module sensor_log_record_deframer_top
    import sldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_index, [8] has_fix, [9] stopped, [15:10] zero
    output logic [3:0]  m_tuser,   // [3:0] word_kind
    output logic        m_tlast
);

    logic    accept;
    result_t core_res;
    result_t out_res;

    assign accept = s_tvalid && s_tready;

    sldf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_word  (s_tdata),
        .res      (core_res)
    );

    sldf_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b0, out_res.stopped, out_res.has_fix, out_res.payload_index};
    assign m_tuser = out_res.word_kind;
    assign m_tlast = out_res.last_of_record;

endmodule

[sim/testbench.sv]
// testbench for the sensor log record deframer: random log streams checked against a predictor
`timescale 1ns / 100ps

module testbench
    import sldf_pkg::*;
;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 700;
    localparam int CALM_WORDS = 60;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [31:0] word;
        bit          drain_first;
    } pending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] payload_index, [8] has_fix, [9] stopped, [15:10] zero
    logic [3:0]  m_tuser;   // [3:0] word_kind
    logic        m_tlast;

    pending_t word_queue[$];
    pending_t head_item;
    result_t  tag_queue[$];
    int       n_sent = 0;
    int       n_checked = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    bit       calm = 1'b0;
    bit       next_valid;
    int       sent_now;
    int       errors = 0;
    int       cycles = 0;
    int       kind_count[9];
    int       fix_count = 0;
    string    stop_cause = "none";
    result_t  pred;
    result_t  want;

    // predictor state
    phase_t      rd_phase = PH_HEADER;
    logic [31:0] remaining = '0;
    rec_class_t  cls = CL_UNKNOWN;
    logic [7:0]  pos = '0;
    logic        fix_hold = 1'b0;
    logic        halt = 1'b0;

    sensor_log_record_deframer_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic logic open_payload(input logic [31:0] count, input rec_class_t c);
        remaining = count;
        cls = c;
        pos = '0;
        fix_hold = 1'b0;
        rd_phase = (count == 0) ? PH_HEADER : PH_PAYLOAD;
        return count == 0;
    endfunction

    function automatic result_t tag_word(input logic [31:0] w);
        result_t    r;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] cnt;
        logic [7:0] p;
        rec_class_t c;
        logic       gnss;
        r.word_kind = KIND_IGNORED;
        r.payload_index = '0;
        r.last_of_record = 1'b0;
        r.has_fix = 1'b0;
        if (!halt)
        begin
            case (rd_phase)
                PH_HEADER:
                begin
                    id = w[7:0];
                    len = w[15:8];
                    cnt = len - 8'd1;
                    if (id == ESCAPE_CODE && len == ESCAPE_CODE)
                    begin
                        r.word_kind = KIND_HEADER;
                        rd_phase = PH_EXT_ID;
                    end
                    else if (len == 0)
                    begin
                        r.word_kind = KIND_ERROR;
                        halt = 1'b1;
                    end
                    else
                    begin
                        c = CL_UNKNOWN;
                        if (id == ID_SENSOR && cnt >= MAIN_WORDS)
                            c = CL_SENSOR;
                        else if (id == ID_GNSS && cnt >= MAIN_WORDS)
                            c = CL_GNSS;
                        else if (id == ID_DGNSS && cnt >= MAIN_WORDS + TAIL_WORDS)
                            c = CL_DGNSS;
                        r.word_kind = KIND_HEADER;
                        r.last_of_record = open_payload({24'd0, cnt}, c);
                    end
                end
                PH_EXT_ID:
                begin
                    r.word_kind = KIND_EXT_ID;
                    rd_phase = PH_EXT_LEN;
                end
                PH_EXT_LEN:
                begin
                    if (w < EXT_MIN_LEN)
                    begin
                        r.word_kind = KIND_ERROR;
                        halt = 1'b1;
                        rd_phase = PH_HEADER;
                    end
                    else
                    begin
                        r.word_kind = KIND_EXT_LEN;
                        r.last_of_record = open_payload(w - EXT_MIN_LEN, CL_UNKNOWN);
                    end
                end
                default:
                begin
                    p = pos;
                    gnss = (cls == CL_GNSS || cls == CL_DGNSS);
                    r.payload_index = p;
                    case (cls)
                        CL_SENSOR: r.word_kind = (p < MAIN_WORDS) ? KIND_SENSOR : KIND_SKIP;
                        CL_GNSS:   r.word_kind = (p < MAIN_WORDS) ? KIND_GNSS : KIND_SKIP;
                        CL_DGNSS:  r.word_kind = (p < MAIN_WORDS) ? KIND_GNSS :
                                       (p < MAIN_WORDS + TAIL_WORDS) ? KIND_TAIL : KIND_SKIP;
                        default:   r.word_kind = KIND_SKIP;
                    endcase
                    if (gnss && p == FIX_WORD)
                        fix_hold = w[24];
                    if (pos != POS_MAX)
                        pos = pos + 8'd1;
                    if (remaining != 0)
                        remaining = remaining - 1;
                    if (remaining == 0)
                    begin
                        r.last_of_record = 1'b1;
                        if (gnss)
                            r.has_fix = fix_hold;
                        rd_phase = PH_HEADER;
                    end
                end
            endcase
        end
        r.stopped = halt;
        return r;
    endfunction

    task automatic push_word(input logic [31:0] w, input bit d);
        pending_t item;
        item.word = w;
        item.drain_first = d;
        word_queue.push_back(item);
    endtask

    task automatic add_record(input logic [7:0] id, input int count, input bit d);
        logic [31:0] h;
        h = $urandom;
        h[15:0] = {8'(count + 1), id};
        push_word(h, d);
        for (int i = 0; i < count; i++)
            push_word($urandom, 1'b0);
    endtask

    task automatic add_extended(input int count, input bit d);
        logic [31:0] h;
        h = $urandom;
        h[15:0] = 16'hffff;
        push_word(h, d);
        push_word($urandom, 1'b0);
        push_word(32'(count) + EXT_MIN_LEN, 1'b0);
        for (int i = 0; i < count; i++)
            push_word($urandom, 1'b0);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            calm <= 1'b0;
        end
        else
        begin
            next_valid = s_tvalid;
            sent_now = n_sent;
            if (s_tvalid && s_tready)
            begin
                pred = tag_word(s_tdata);
                tag_queue.push_back(pred);
                kind_count[pred.word_kind]++;
                fix_count += int'(pred.has_fix);
                sent_now = n_sent + 1;
                next_valid = 1'b0;
            end
            n_sent <= sent_now;
            if (!next_valid)
            begin
                if (gap_left != 0)
                    gap_left = gap_left - 1;
                else if (word_queue.size() != 0 &&
                         !(word_queue[0].drain_first && sent_now != n_checked))
                begin
                    head_item = word_queue.pop_front();
                    s_tdata <= head_item.word;
                    next_valid = 1'b1;
                    if (word_queue.size() >= CALM_WORDS && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 12);
                end
            end
            s_tvalid <= next_valid;
            calm <= (word_queue.size() < CALM_WORDS);
        end
    end

    task automatic report(input string field, input logic [31:0] exp_v,
                          input logic [31:0] got_v);
        $display("%0t %s: expected %0d, got %0d", $time, field, exp_v, got_v);
        errors++;
    endtask

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (tag_queue.size() == 0)
                begin
                    $display("%0t unexpected transaction: expected none, got kind %0d",
                             $time, m_tuser);
                    errors++;
                end
                else
                begin
                    want = tag_queue.pop_front();
                    if (m_tuser !== want.word_kind)
                        report("word_kind", 32'(want.word_kind), 32'(m_tuser));
                    if (m_tdata[7:0] !== want.payload_index)
                        report("payload_index", 32'(want.payload_index), 32'(m_tdata[7:0]));
                    if (m_tlast !== want.last_of_record)
                        report("last_of_record", 32'(want.last_of_record), 32'(m_tlast));
                    if (m_tdata[8] !== want.has_fix)
                        report("has_fix", 32'(want.has_fix), 32'(m_tdata[8]));
                    if (m_tdata[9] !== want.stopped)
                        report("stopped", 32'(want.stopped), 32'(m_tdata[9]));
                end
                n_checked <= n_checked + 1;
            end
            if (stall_left != 0)
                stall_left = stall_left - 1;
            else if (!calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("sensor_log_record_deframer_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         pick;
        int         extra;
        int         need;
        bit         drain;
        logic [7:0] id;
        logic [31:0] h;

        // empty payloads and extreme header values
        push_word(32'h0000_0100, 1'b0);
        push_word(32'hffff_01fe, 1'b0);
        push_word(32'h0000_01ff, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'd3, 1'b0);
        // extended record with a short skipped payload
        push_word(32'h0000_ffff, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        // known ids too short to classify, and an unknown id
        push_word(32'h0000_0214, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h0000_031e, 1'b0);
        push_word(32'h0100_0000, 1'b0);
        push_word(32'hfeff_ffff, 1'b0);
        push_word(32'h0000_0363, 1'b0);
        push_word(32'h5555_5555, 1'b0);
        push_word(32'haaaa_aaaa, 1'b0);

        // long extended record drives the position counter into saturation
        add_extended($urandom_range(257, 270), 1'b1);

        while (word_queue.size() < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            drain = ($urandom_range(0, 24) == 0);
            if (pick < 28)
                add_record(ID_SENSOR, int'(MAIN_WORDS) + extra, drain);
            else if (pick < 52)
                add_record(ID_GNSS, int'(MAIN_WORDS) + extra, drain);
            else if (pick < 72)
                add_record(ID_DGNSS, int'(MAIN_WORDS) + int'(TAIL_WORDS) + extra, drain);
            else if (pick < 80)
            begin
                case ($urandom_range(0, 2))
                    0: begin id = ID_SENSOR; need = int'(MAIN_WORDS); end
                    1: begin id = ID_GNSS; need = int'(MAIN_WORDS); end
                    default:
                    begin
                        id = ID_DGNSS;
                        need = int'(MAIN_WORDS) + int'(TAIL_WORDS);
                    end
                endcase
                add_record(id, $urandom_range(0, need - 1), drain);
            end
            else if (pick < 90)
            begin
                id = 8'($urandom_range(0, 255));
                while (id == ID_SENSOR || id == ID_GNSS || id == ID_DGNSS)
                    id = 8'($urandom_range(0, 255));
                add_record(id, $urandom_range(0, 20), drain);
            end
            else if (pick < 96)
                add_extended($urandom_range(0, 12), drain);
            else
                add_record(8'($urandom_range(0, 255)), $urandom_range(0, 253), drain);
        end

        // corrupt length stops the stream; the rest is ignored
        if ($urandom_range(0, 1) == 0)
        begin
            stop_cause = "zero header length";
            h = $urandom;
            h[15:8] = 8'd0;
            push_word(h, 1'b0);
        end
        else
        begin
            stop_cause = "short extended length";
            h = $urandom;
            h[15:0] = 16'hffff;
            push_word(h, 1'b0);
            push_word($urandom, 1'b0);
            push_word($urandom_range(0, 2), 1'b0);
        end
        for (int i = 0; i < 10; i++)
            push_word($urandom, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (word_queue.size() != 0 || s_tvalid || n_sent != n_checked)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tag_queue.size() != 0)
        begin
            $display("%0t missing transactions: expected %0d more, got none",
                     $time, tag_queue.size());
            errors++;
        end

        $display("covered %0d words: %0d headers, %0d ext id, %0d ext len, %0d sensor",
                 n_sent, kind_count[KIND_HEADER], kind_count[KIND_EXT_ID],
                 kind_count[KIND_EXT_LEN], kind_count[KIND_SENSOR]);
        $display("%0d gnss, %0d tail, %0d skipped, %0d fix flags, stopped by %s, %0d ignored",
                 kind_count[KIND_GNSS], kind_count[KIND_TAIL], kind_count[KIND_SKIP],
                 fix_count, stop_cause, kind_count[KIND_IGNORED]);
        if (errors == 0)
            $display("sensor_log_record_deframer_top: match");
        else
            $display("sensor_log_record_deframer_top: mismatch");
        $finish;
    end

endmodule
